FILE: hw/rtl/assert_macros.svh
// assertion macros used by the back of the median / smoothing core
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WMED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WMED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WMED_ASSERT(lbl, prop, msg)
`define WMED_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/wmed_pkg.sv
// types and constants of the windowed median / smoothing core
// no dependencies
package wmed_pkg;

  localparam int ValW = 24;
  localparam int NumEst = 3;
  localparam int EstIfft = 0;
  localparam int EstPhase = 1;
  localparam int EstRtt = 2;
  localparam logic [15:0] AlphaReset = 16'd9830;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [1:0]             path_index;
    logic signed [ValW-1:0] ifft_estimate;
    logic                   ifft_present;
    logic signed [ValW-1:0] phase_estimate;
    logic                   phase_present;
    logic signed [ValW-1:0] rtt_estimate;
    logic                   rtt_present;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] median_ifft;
    logic                   median_ifft_ok;
    logic signed [ValW-1:0] median_phase;
    logic                   median_phase_ok;
    logic signed [ValW-1:0] median_rtt;
    logic                   median_rtt_ok;
    logic signed [ValW-1:0] smoothed_distance;
    logic                   smoothed_ok;
  } out_t;

  // queue entry between front and back
  typedef struct packed {
    logic is_restart;
    in_t  item;
  } fe_t;

  typedef struct packed {
    logic empty;
    fe_t  data;
  } fq_t;

  // one window entry, all three estimators
  typedef struct packed {
    logic [NumEst-1:0]           pres;
    logic [NumEst-1:0][ValW-1:0] val;
  } win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_RANK,
    ST_MED,
    ST_EMA1,
    ST_EMA2,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/wmed_fifo.sv
// two-entry queue used between front and back and on the result side
// depends on nothing
module wmed_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty
);
  logic [DW-1:0] ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= din;
  end
endmodule

FILE: hw/rtl/wmed_front.sv
// front: accepts items, drops pushes to absent paths, queues the rest
// depends on wmed_pkg, wmed_fifo
module wmed_front #(
  parameter int NUM_PATHS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  wmed_pkg::in_t in_data,
  output logic          in_full,
  output wmed_pkg::fq_t fq,
  input  logic          fq_pop
);
  import wmed_pkg::*;

  fe_t  ent;
  logic keep;
  logic q_empty;
  fe_t  q_data;

  always_comb begin
    ent.is_restart = (in_data.opcode == OP_RESTART);
    ent.item = in_data;
    keep = ent.is_restart || ({1'b0, in_data.path_index} < 3'(NUM_PATHS));
  end

  wmed_fifo #(.DW($bits(fe_t))) u_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push && keep), .din(ent), .full(in_full),
    .pop(fq_pop), .dout(q_data), .empty(q_empty)
  );

  assign fq.empty = q_empty;
  assign fq.data = q_data;
endmodule

FILE: hw/rtl/wmed_back.sv
// back: window memory, rank-count median per estimator, moving average
// depends on wmed_pkg, wmed_fifo, assert_macros.svh
module wmed_back #(
  parameter int WINDOW_LEN = 9,
  parameter int NUM_PATHS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wmed_pkg::fq_t  fq,
  output logic           fq_pop,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  output logic           out_empty,
  input  logic           out_pop,
  output wmed_pkg::out_t out_data
);
  import wmed_pkg::*;
`include "assert_macros.svh"

  localparam int Depth = NUM_PATHS * WINDOW_LEN;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam int PW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;

  state_t state_r, state_nxt;

  win_t mem [Depth];
  win_t mem_q_r;
  win_t buf_r [WINDOW_LEN];

  logic [SW-1:0] slot_r [NUM_PATHS];
  logic [CW-1:0] fill_r [NUM_PATHS];
  logic [PW-1:0] path_r;
  logic [AW-1:0] base_r;
  in_t           cur_r;
  logic [CW-1:0] fill_cur_r;
  logic [CW-1:0] k_r;
  logic          rdv_r;
  logic [SW-1:0] rdidx_r;
  logic [SW-1:0] ri_r;
  logic [CW-1:0] n_r [NumEst];
  logic [ValW-1:0] lo_r [NumEst];
  logic [ValW-1:0] hi_r [NumEst];
  logic [ValW-1:0] med_r [NumEst];
  logic [NumEst-1:0] ok_r;
  logic [15:0]   alpha_r;
  logic signed [41:0] prod_r;
  logic signed [ValW-1:0] avg_r;
  logic          loaded_r;

  logic mem_we, rd_issue, oq_push, oq_full;
  logic [SW-1:0] slot_cur;
  logic [CW-1:0] cnt [NumEst];
  win_t cand;
  win_t wr_ent;
  out_t res;
  logic signed [24:0] diff;
  logic signed [41:0] t_sum;
  logic signed [26:0] nv;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!fq.empty && !fq.data.is_restart) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_READ;
      ST_READ: if (k_r == fill_cur_r && !rdv_r) state_nxt = ST_RANK;
      ST_RANK: if (CW'(ri_r) == fill_cur_r - CW'(1)) state_nxt = ST_MED;
      ST_MED: state_nxt = ST_EMA1;
      ST_EMA1: state_nxt = ST_EMA2;
      ST_EMA2: state_nxt = ST_OUT;
      ST_OUT: if (!oq_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    fq_pop = 1'b0;
    mem_we = 1'b0;
    rd_issue = 1'b0;
    oq_push = 1'b0;
    case (state_r)
      ST_IDLE: fq_pop = !fq.empty;
      ST_WRITE: mem_we = 1'b1;
      ST_READ: rd_issue = (k_r < fill_cur_r);
      ST_OUT: oq_push = !oq_full;
      default: ;
    endcase
  end

  assign slot_cur = slot_r[path_r];

  always_comb begin
    wr_ent.pres = {cur_r.rtt_present, cur_r.phase_present, cur_r.ifft_present};
    wr_ent.val = {cur_r.rtt_estimate, cur_r.phase_estimate, cur_r.ifft_estimate};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[base_r + AW'(slot_cur)] <= wr_ent;
    if (rd_issue) mem_q_r <= mem[base_r + AW'(k_r)];
  end

  // rank of the candidate among present entries, ties broken by position
  always_comb begin
    cand = buf_r[ri_r];
    for (int e = 0; e < NumEst; e++) begin
      cnt[e] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (CW'(j) < fill_cur_r && buf_r[j].pres[e] &&
            (($signed(buf_r[j].val[e]) < $signed(cand.val[e])) ||
             ((buf_r[j].val[e] == cand.val[e]) && (SW'(j) < ri_r))))
          cnt[e] = cnt[e] + CW'(1);
      end
    end
  end

  always_comb begin
    diff = {med_r[EstIfft][ValW-1], med_r[EstIfft]} - {avg_r[ValW-1], avg_r};
    t_sum = prod_r + 42'sd32768;
    nv = {{3{avg_r[ValW-1]}}, avg_r} + {t_sum[41], t_sum[41:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int p = 0; p < NUM_PATHS; p++) begin
        slot_r[p] <= '0;
        fill_r[p] <= '0;
      end
      rdv_r <= 1'b0;
      avg_r <= '0;
      loaded_r <= 1'b0;
      alpha_r <= AlphaReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) alpha_r <= cfg_wdata;
      rdv_r <= rd_issue;
      case (state_r)
        ST_IDLE: begin
          if (!fq.empty && fq.data.is_restart) loaded_r <= 1'b0;
        end
        ST_WRITE: begin
          slot_r[path_r] <= (slot_cur == SW'(WINDOW_LEN - 1)) ? '0 : slot_cur + SW'(1);
          if (fill_r[path_r] < CW'(WINDOW_LEN)) fill_r[path_r] <= fill_r[path_r] + CW'(1);
        end
        ST_EMA2: begin
          if (ok_r[EstIfft]) begin
            loaded_r <= 1'b1;
            if (!loaded_r) avg_r <= med_r[EstIfft];
            else if (nv > 27'sd8388607) avg_r <= 24'sh7fffff;
            else if (nv < -27'sd8388608) avg_r <= 24'sh800000;
            else avg_r <= nv[ValW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cur_r <= fq.data.item;
        path_r <= fq.data.item.path_index[PW-1:0];
        base_r <= AW'(fq.data.item.path_index[PW-1:0]) * AW'(WINDOW_LEN);
      end
      ST_WRITE: begin
        fill_cur_r <= (fill_r[path_r] < CW'(WINDOW_LEN)) ? fill_r[path_r] + CW'(1)
                                                          : fill_r[path_r];
        k_r <= '0;
        for (int e = 0; e < NumEst; e++) n_r[e] <= '0;
      end
      ST_READ: begin
        if (rd_issue) k_r <= k_r + CW'(1);
        rdidx_r <= k_r[SW-1:0];
        if (rdv_r) begin
          buf_r[rdidx_r] <= mem_q_r;
          for (int e = 0; e < NumEst; e++)
            if (mem_q_r.pres[e]) n_r[e] <= n_r[e] + CW'(1);
        end
        ri_r <= '0;
      end
      ST_RANK: begin
        ri_r <= ri_r + SW'(1);
        for (int e = 0; e < NumEst; e++) begin
          if (cand.pres[e] && cnt[e] == ((n_r[e] - CW'(1)) >> 1)) lo_r[e] <= cand.val[e];
          if (cand.pres[e] && cnt[e] == (n_r[e] >> 1)) hi_r[e] <= cand.val[e];
        end
      end
      ST_MED: begin
        for (int e = 0; e < NumEst; e++) begin
          logic [ValW:0] s;
          s = {lo_r[e][ValW-1], lo_r[e]} + {hi_r[e][ValW-1], hi_r[e]};
          ok_r[e] <= (n_r[e] != '0);
          med_r[e] <= (n_r[e] != '0) ? s[ValW:1] : '0;
        end
      end
      ST_EMA1: prod_r <= $signed({1'b0, alpha_r}) * diff;
      default: ;
    endcase
  end

  always_comb begin
    res.median_ifft = med_r[EstIfft];
    res.median_ifft_ok = ok_r[EstIfft];
    res.median_phase = med_r[EstPhase];
    res.median_phase_ok = ok_r[EstPhase];
    res.median_rtt = med_r[EstRtt];
    res.median_rtt_ok = ok_r[EstRtt];
    res.smoothed_distance = loaded_r ? avg_r : '0;
    res.smoothed_ok = loaded_r;
  end

  wmed_fifo #(.DW($bits(out_t))) u_oq (
    .clk(clk), .rst_n(rst_n),
    .push(oq_push), .din(res), .full(oq_full),
    .pop(out_pop), .dout(out_data), .empty(out_empty)
  );

  `WMED_ASSERT(a_rank_in_fill, (state_r == ST_RANK) |-> (CW'(ri_r) < fill_cur_r), "rank index past fill")
  `WMED_ASSERT(a_fill_nonzero, (state_r == ST_READ) |-> (fill_cur_r != '0), "empty window after write")
  `WMED_ASSERT(a_out_done, (state_r == ST_OUT && !oq_full) |=> (state_r == ST_IDLE), "result not retired")
endmodule

FILE: hw/rtl/windowed_median_ema_distance_core.sv
// top level of the windowed median / moving average distance core
// depends on wmed_pkg, wmed_front, wmed_back
//
// channel   ports                          beat moves
// input     in_push / in_full / in_data    one opcode plus path estimates
// result    out_pop / out_empty / out_data medians and smoothed distance
// config    cfg_we / cfg_wdata             smoothing weight, q0.16
//
// a push beat runs through the back sequencer over fill <= WINDOW_LEN window entries,
//   with one window read per cycle and one rank pass per entry
// restart beats only reset the smoothed average, pushes to absent paths are dropped at the front
// reset is synchronous; windows need no clearing, fill counts gate the reads
// two-entry queues on both sides let input and result stall independently
module windowed_median_ema_distance_core #(
  parameter int WINDOW_LEN = 9,
  parameter int NUM_PATHS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  wmed_pkg::in_t  in_data,
  output logic           in_full,
  output logic           out_empty,
  input  logic           out_pop,
  output wmed_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);
  import wmed_pkg::*;

  // front to back queue view
  fq_t  fq;
  logic fq_pop;

  // front: classify and buffer beats
  wmed_front #(.NUM_PATHS(NUM_PATHS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .fq(fq), .fq_pop(fq_pop)
  );

  // back: window update, medians, smoothing, result queue
  wmed_back #(.WINDOW_LEN(WINDOW_LEN), .NUM_PATHS(NUM_PATHS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .fq(fq), .fq_pop(fq_pop),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );
endmodule
